### rtl/core/lps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and command codes for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Command carried by each input item
  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/line_pixel_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Integer line rasterizer: load two endpoints, then walk the line one pixel
// per step command using the classic error-term stepping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): a load item (cmd = load) takes start
//   and end points and produces the start pixel; a step item produces the
//   next pixel along the major axis. A step with no line active produces an
//   item with is_valid = 0 and zero coordinates.
//   Result channel (out_valid/out_ready): exactly one item per input item.
//   out_valid rises in the cycle after input accept. Throughput is one
//   item per cycle while the receiver takes results, as the error term and
//   the current pixel, which each item reads and writes, update on accept.
//   The result register accepts a new item while its current item is taken
//   in the same cycle; when the receiver stalls, in_ready drops and the
//   pending result holds.
//   Reset (rst_n low, synchronous) clears out_valid and leaves no line
//   active. A load while a line is active replaces it.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_cmd,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic                       out_is_last,
  output logic                       out_is_valid
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  // Line state
  logic [CW-1:0]        cur_x_r, cur_x_nxt;
  logic [CW-1:0]        cur_y_r, cur_y_nxt;
  logic [CW-1:0]        target_x_r, target_x_nxt;
  logic [CW-1:0]        target_y_r, target_y_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [CW-1:0]        abs_dx_r, abs_dx_nxt;
  logic [CW-1:0]        abs_dy_r, abs_dy_nxt;
  logic                 x_major_r, x_major_nxt;
  logic                 step_neg_r, step_neg_nxt;
  logic                 same_sign_r, same_sign_nxt;
  logic                 running_r, running_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        px_r, px_nxt;
  logic [CW-1:0]        py_r, py_nxt;
  logic                 last_r, last_nxt;
  logic                 pvalid_r, pvalid_nxt;

  logic                 in_fire;

  // Load path terms
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        ld_adx, ld_ady;
  logic                 ld_xmaj;
  logic signed [EW-1:0] ld_adx_e, ld_ady_e;

  // Step path terms
  logic                 minor_neg;
  logic signed [EW-1:0] st_adx_e, st_ady_e;
  logic                 st_last;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Deltas and their magnitudes for a load, plus the step path terms
  always_comb begin
    dx       = $signed({1'b0, in_end_x}) - $signed({1'b0, in_start_x});
    dy       = $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
    ld_adx   = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ld_ady   = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    ld_xmaj  = ld_ady <= ld_adx;
    ld_adx_e = $signed({3'b000, ld_adx});
    ld_ady_e = $signed({3'b000, ld_ady});
    st_adx_e = $signed({3'b000, abs_dx_r});
    st_ady_e = $signed({3'b000, abs_dy_r});
    minor_neg = step_neg_r ^ !same_sign_r;
  end

  // Next state and next result
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    target_x_nxt  = target_x_r;
    target_y_nxt  = target_y_r;
    err_nxt       = err_r;
    abs_dx_nxt    = abs_dx_r;
    abs_dy_nxt    = abs_dy_r;
    x_major_nxt   = x_major_r;
    step_neg_nxt  = step_neg_r;
    same_sign_nxt = same_sign_r;
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r && !out_ready;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    pvalid_nxt    = pvalid_r;
    st_last       = 1'b0;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (in_cmd == lps_pkg::CMD_LOAD) begin
        // Load endpoints and emit the start pixel
        abs_dx_nxt    = ld_adx;
        abs_dy_nxt    = ld_ady;
        x_major_nxt   = ld_xmaj;
        step_neg_nxt  = ld_xmaj ? !(in_start_x < in_end_x) : !(in_start_y < in_end_y);
        same_sign_nxt = (dx[CW] && dy[CW]) ||
                        (!dx[CW] && (dx != '0) && !dy[CW] && (dy != '0));
        err_nxt       = ld_xmaj ? ((ld_ady_e <<< 1) - ld_adx_e)
                                : ((ld_adx_e <<< 1) - ld_ady_e);
        cur_x_nxt     = in_start_x;
        cur_y_nxt     = in_start_y;
        target_x_nxt  = in_end_x;
        target_y_nxt  = in_end_y;
        st_last       = ld_xmaj ? (in_start_x == in_end_x) : (in_start_y == in_end_y);
        running_nxt   = !st_last;
        px_nxt        = in_start_x;
        py_nxt        = in_start_y;
        last_nxt      = st_last;
        pvalid_nxt    = 1'b1;
      end else if (!running_r) begin
        // Drop the step: no line active
        px_nxt     = '0;
        py_nxt     = '0;
        last_nxt   = 1'b0;
        pvalid_nxt = 1'b0;
      end else begin
        // Advance one pixel along the major axis
        if (x_major_r) begin
          cur_x_nxt = step_neg_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
          if (err_r < 0) begin
            err_nxt = err_r + (st_ady_e <<< 1);
          end else begin
            cur_y_nxt = minor_neg ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);
            err_nxt   = err_r + ((st_ady_e - st_adx_e) <<< 1);
          end
          st_last = cur_x_nxt == target_x_r;
        end else begin
          cur_y_nxt = step_neg_r ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);
          if (err_r <= 0) begin
            err_nxt = err_r + (st_adx_e <<< 1);
          end else begin
            cur_x_nxt = minor_neg ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
            err_nxt   = err_r + ((st_adx_e - st_ady_e) <<< 1);
          end
          st_last = cur_y_nxt == target_y_r;
        end
        running_nxt = !st_last;
        px_nxt      = cur_x_nxt;
        py_nxt      = cur_y_nxt;
        last_nxt    = st_last;
        pvalid_nxt  = 1'b1;
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      target_x_r  <= '0;
      target_y_r  <= '0;
      err_r       <= '0;
      abs_dx_r    <= '0;
      abs_dy_r    <= '0;
      x_major_r   <= 1'b0;
      step_neg_r  <= 1'b0;
      same_sign_r <= 1'b0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      target_x_r  <= target_x_nxt;
      target_y_r  <= target_y_nxt;
      err_r       <= err_nxt;
      abs_dx_r    <= abs_dx_nxt;
      abs_dy_r    <= abs_dy_nxt;
      x_major_r   <= x_major_nxt;
      step_neg_r  <= step_neg_nxt;
      same_sign_r <= same_sign_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload holds without reset
  always_ff @(posedge clk) begin
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    last_r   <= last_nxt;
    pvalid_r <= pvalid_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = px_r;
  assign out_pixel_y  = py_r;
  assign out_is_last  = last_r;
  assign out_is_valid = pvalid_r;

`ifndef ASSERT_OFF
  // The line stays active exactly when the latest pixel was not the last
  a_running_vs_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pvalid_r) |-> (running_r == !last_r))
    else $error("running flag disagrees with last pixel");

  // A last marker only comes with a real pixel
  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> pvalid_r)
    else $error("last set on an invalid item");

  // A step with no active line yields an invalid item
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == lps_pkg::CMD_STEP) && !running_r) |=>
      (out_valid_r && !pvalid_r))
    else $error("step without active line produced a pixel");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_pixel_stepper. A short directed table covers
// corner lines (extremes, zero length, axis-parallel, error ties, replacing
// an active line, steps with no line active). Random well-formed lines with
// random content and some noise follow. Each pixel is checked against an
// in-bench Bresenham predictor, first under random sender and receiver stalls, then at full rate.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COORD_BITS    = 12;
  localparam int ERR_BITS      = COORD_BITS + 3;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   is_last;
    logic   is_valid;
  } pix_t;

  typedef struct packed {
    logic known;
    pix_t want;
  } check_t;

  typedef struct packed {
    lps_pkg::cmd_t cmd;
    coord_t        sx;
    coord_t        sy;
    coord_t        ex;
    coord_t        ey;
    logic          known;
    pix_t          want;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  lps_pkg::cmd_t in_cmd = lps_pkg::CMD_LOAD;
  coord_t        in_start_x = '0;
  coord_t        in_start_y = '0;
  coord_t        in_end_x = '0;
  coord_t        in_end_y = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  coord_t        out_pixel_x;
  coord_t        out_pixel_y;
  logic          out_is_last;
  logic          out_is_valid;

  // Predictor state: one line in flight
  coord_t pen_x, pen_y, goal_x, goal_y;
  coord_t span_x, span_y;
  err_t   err_acc;
  logic   x_major, step_neg, same_sign, line_active;

  pix_t   pending_pixels[$];
  check_t placed_checks[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int errors = 0;
  int cycle_count = 0;
  int loads_seen = 0;
  int steps_seen = 0;
  int blank_pixels = 0;
  int line_ends = 0;

  row_t plan [25];

  line_pixel_stepper #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_is_last (out_is_last),
    .out_is_valid(out_is_valid)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Work out the pixel one item yields and advance the line state
  task automatic predict_pixel(input lps_pkg::cmd_t c, input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey, output pix_t r);
    int   dx, dy;
    logic at_end;
    logic minor_neg;
    r = '0;
    if (c == lps_pkg::CMD_LOAD) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      span_x = coord_t'((dx < 0) ? -dx : dx);
      span_y = coord_t'((dy < 0) ? -dy : dy);
      x_major = (span_y <= span_x);
      step_neg = x_major ? !(sx < ex) : !(sy < ey);
      same_sign = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
      if (x_major) begin
        err_acc = err_t'(2 * int'(span_y) - int'(span_x));
      end else begin
        err_acc = err_t'(2 * int'(span_x) - int'(span_y));
      end
      pen_x = sx;
      pen_y = sy;
      goal_x = ex;
      goal_y = ey;
      at_end = x_major ? (sx == ex) : (sy == ey);
      line_active = !at_end;
      r = '{sx, sy, at_end, 1'b1};
    end else if (line_active) begin
      minor_neg = step_neg ^ !same_sign;
      if (x_major) begin
        pen_x = step_neg ? pen_x - 1'b1 : pen_x + 1'b1;
        if (err_acc < 0) begin
          err_acc = err_t'(int'(err_acc) + 2 * int'(span_y));
        end else begin
          pen_y = minor_neg ? pen_y - 1'b1 : pen_y + 1'b1;
          err_acc = err_t'(int'(err_acc) + 2 * (int'(span_y) - int'(span_x)));
        end
        at_end = (pen_x == goal_x);
      end else begin
        pen_y = step_neg ? pen_y - 1'b1 : pen_y + 1'b1;
        if (err_acc <= 0) begin
          err_acc = err_t'(int'(err_acc) + 2 * int'(span_x));
        end else begin
          pen_x = minor_neg ? pen_x - 1'b1 : pen_x + 1'b1;
          err_acc = err_t'(int'(err_acc) + 2 * (int'(span_x) - int'(span_y)));
        end
        at_end = (pen_y == goal_y);
      end
      line_active = !at_end;
      r = '{pen_x, pen_y, at_end, 1'b1};
    end
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    $display("[%0t] mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Check each result against the oldest expectation; predict on each accept
  always @(posedge clk) begin : watch
    pix_t   got;
    pix_t   want;
    check_t tag;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_pixel_x, out_pixel_y, out_is_last, out_is_valid};
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("[%0t] unexpected pixel (%0d,%0d) last=%0d valid=%0d", $time,
                   got.px, got.py, got.is_last, got.is_valid);
        end else begin
          want = pending_pixels.pop_front();
          if (got.px != want.px) note_mismatch("pixel_x", want.px, got.px);
          if (got.py != want.py) note_mismatch("pixel_y", want.py, got.py);
          if (got.is_last != want.is_last) note_mismatch("is_last", want.is_last, got.is_last);
          if (got.is_valid != want.is_valid)
            note_mismatch("is_valid", want.is_valid, got.is_valid);
        end
        if (!got.is_valid) blank_pixels++;
        if (got.is_last) line_ends++;
      end
      if (in_valid && in_ready) begin
        tag = placed_checks.pop_front();
        predict_pixel(in_cmd, in_start_x, in_start_y, in_end_x, in_end_y, want);
        if (tag.known) want = tag.want;
        pending_pixels = {pending_pixels, want};
        if (in_cmd == lps_pkg::CMD_LOAD) loads_seen++;
        else steps_seen++;
      end
    end
  end

  // Offer one item, idling first at the current rate, and hold until taken
  task automatic send_item(input lps_pkg::cmd_t c, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic known, input pix_t want);
    check_t entry;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    entry = '{known, want};
    placed_checks = {placed_checks, entry};
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Move a coordinate by d, folding back when it would leave the grid
  function automatic coord_t reach(input coord_t s, input int d);
    int e;
    e = int'(s) + d;
    if (e > COORD_MAX || e < 0) e = int'(s) - d;
    return coord_t'(e);
  endfunction

  // Send one random line with its steps, or a single noise item
  task automatic send_line();
    coord_t sx, sy, ex, ey;
    int     pick, span, len, steps;
    pick = $urandom_range(99);
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    if (pick < 8) begin
      send_item(lps_pkg::cmd_t'($urandom_range(1)), sx, sy, coord_t'($urandom),
                coord_t'($urandom), 1'b0, '0);
    end else begin
      if (pick < 83) span = 12;
      else if (pick < 95) span = 100;
      else span = 0;
      if (span != 0) begin
        ex = reach(sx, int'($urandom_range(2 * span)) - span);
        ey = reach(sy, int'($urandom_range(2 * span)) - span);
      end else begin
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
      len = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
      if (((ey > sy) ? int'(ey - sy) : int'(sy - ey)) > len)
        len = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
      if (span == 0) steps = $urandom_range(30);
      else if ($urandom_range(99) < 15) steps = $urandom_range(len);
      else steps = len + $urandom_range(2);
      send_item(lps_pkg::CMD_LOAD, sx, sy, ex, ey, 1'b0, '0);
      repeat (steps) begin
        send_item(lps_pkg::CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    // Directed corner lines; expected pixel given where it is plain
    plan = '{
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b0, 1'b0}},
      '{lps_pkg::CMD_LOAD, 7, 9, 7, 9, 1'b1, '{7, 9, 1'b1, 1'b1}},
      '{lps_pkg::CMD_STEP, 4095, 4095, 4095, 4095, 1'b1, '{0, 0, 1'b0, 1'b0}},
      '{lps_pkg::CMD_LOAD, 0, 0, 4095, 4095, 1'b1, '{0, 0, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_LOAD, 4095, 4095, 0, 0, 1'b1, '{4095, 4095, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_LOAD, 4095, 0, 0, 4095, 1'b1, '{4095, 0, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_LOAD, 0, 4095, 4095, 0, 1'b1, '{0, 4095, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_LOAD, 10, 10, 12, 11, 1'b1, '{10, 10, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b0, 1'b0}},
      '{lps_pkg::CMD_LOAD, 20, 20, 21, 22, 1'b1, '{20, 20, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_LOAD, 5, 5, 5, 2, 1'b1, '{5, 5, 1'b0, 1'b1}},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, '0},
      '{lps_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b0, 1'b0}},
      '{lps_pkg::CMD_LOAD, 100, 50, 90, 50, 1'b1, '{100, 50, 1'b0, 1'b1}}
    };

    // Hold reset, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow receiver first, then slow sender, then full rate
    tx_idle_pct = 25;
    rx_idle_pct = 67;
    foreach (plan[i]) begin
      send_item(plan[i].cmd, plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey,
                plan[i].known, plan[i].want);
    end
    while (items_sent < $size(plan) + RANDOM_ITEMS) begin
      if (items_sent >= $size(plan) + 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (items_sent >= $size(plan) + RANDOM_ITEMS / 3) begin
        tx_idle_pct = 67;
        rx_idle_pct = 25;
      end
      send_line();
    end
    in_valid <= 1'b0;

    // Drain, then let any stray result show up
    rx_idle_pct = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      $display("[%0t] expected %0d more pixels, actual 0", $time, pending_pixels.size());
    end

    $display("Covered %0d loads and %0d steps: %0d line ends, %0d steps with no line.",
             loads_seen, steps_seen, line_ends, blank_pixels);
    $display("Mismatches: %0d over %0d cycles.", errors, cycle_count);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lps_pkg.sv
rtl/core/line_pixel_stepper.sv
tb/testbench.sv
